FILE: rtl/tsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg: shared types and constants of the snapshot interpolator
// Field widths, action and status codes, controller state, command bundles.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int unsigned Entities  = 256;
  localparam int unsigned Depth     = 4;
  localparam int unsigned EntW      = 8;
  localparam int unsigned SlotW     = $clog2(Depth);
  localparam int unsigned AddrW     = EntW + SlotW;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam logic [15:0] NoParent  = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_STALE = 2'd1,
    ST_SKIP  = 2'd2,
    ST_VALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] ang;
    logic [15:0] parent;
  } snap_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_RDW, S_CHK, S_WR, S_SCAN, S_SCANW,
    S_DIV, S_ADD, S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       init;      // reset clear pass step
    logic       load;      // capture input transaction
    logic       rd;        // read slot
    logic       rd_cap;    // capture read data
    logic       wr;        // write slot
    logic       wr_clr;    // write reset value
    logic       wr_new;    // write new snapshot (else shifted)
    logic       div_start;
    logic       add;
    logic       out_load;
    logic [1:0] status;
    logic       interp;
    logic [SlotW-1:0] slot;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       init_done;
    logic       div_done;
    logic       inrange;
    logic       newer;     // stamp above newest
    logic       zero_t;
    logic       later;     // read stamp > T
    logic       rd_zero;   // read stamp == 0
    logic       prev_ok;   // interpolation allowed
    logic [1:0] action;
  } sts_t;

endpackage

FILE: rtl/tsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_in_if / tsi_out_if: valid-ready channels of the interpolator
// One transaction per handshake.
// ----------------------------------------------------------------------------
interface tsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  entity;
  logic [31:0] stamp;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] angle;
  logic [15:0] parent_id;
  modport source (output valid, action, entity, stamp, pos_x, pos_y, angle, parent_id,
                  input ready);
  modport sink   (input valid, action, entity, stamp, pos_x, pos_y, angle, parent_id,
                  output ready);
endinterface

interface tsi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_angle;
  logic [15:0] out_parent;
  logic        link_parent;
  modport source (output valid, status, out_x, out_y, out_angle, out_parent, link_parent,
                  input ready);
  modport sink   (input valid, status, out_x, out_y, out_angle, out_parent, link_parent,
                  output ready);
endinterface

FILE: rtl/tsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_div: shared restoring divider
// Three 64-by-32 unsigned quotients, one bit per cycle each.
// ----------------------------------------------------------------------------
module tsi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_x_i,
  input  logic [63:0] num_y_i,
  input  logic [63:0] num_a_i,
  input  logic [31:0] den_i,
  output logic [63:0] q_x_o,
  output logic [63:0] q_y_o,
  output logic [63:0] q_a_o,
  output logic        done_o
);
  logic [63:0] qx_q, qy_q, qa_q;
  logic [32:0] rx_q, ry_q, ra_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] tx, ty, ta;

  assign tx = {rx_q[31:0], qx_q[63]};
  assign ty = {ry_q[31:0], qy_q[63]};
  assign ta = {ra_q[31:0], qa_q[63]};

  // done_q rises once the last quotient bit is in place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd63);
      if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qx_q <= num_x_i; qy_q <= num_y_i; qa_q <= num_a_i;
      rx_q <= '0; ry_q <= '0; ra_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (tx >= {1'b0, den_q}) begin
        rx_q <= tx - {1'b0, den_q}; qx_q <= {qx_q[62:0], 1'b1};
      end else begin
        rx_q <= tx; qx_q <= {qx_q[62:0], 1'b0};
      end
      if (ty >= {1'b0, den_q}) begin
        ry_q <= ty - {1'b0, den_q}; qy_q <= {qy_q[62:0], 1'b1};
      end else begin
        ry_q <= ty; qy_q <= {qy_q[62:0], 1'b0};
      end
      if (ta >= {1'b0, den_q}) begin
        ra_q <= ta - {1'b0, den_q}; qa_q <= {qa_q[62:0], 1'b1};
      end else begin
        ra_q <= ta; qa_q <= {qa_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign q_x_o = qx_q;
  assign q_y_o = qy_q;
  assign q_a_o = qa_q;
endmodule

FILE: rtl/tsi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_datapath: snapshot memory, operand registers and interpolation
// Single-port snapshot memory, per-field delta and product, divider, sum.
// ----------------------------------------------------------------------------
module tsi_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsi_pkg::cmd_t   cmd_i,
  output tsi_pkg::sts_t   sts_o,
  tsi_in_if.sink          in_if,
  tsi_out_if.source       out_if
);
  import tsi_pkg::*;

  snap_t mem_q [Entities*Depth];
  snap_t rd_q, cur_q, prev_q, wdat;
  logic [AddrW-1:0] init_q, addr;
  logic             init_done_q;

  logic [1:0]  act_q;
  logic [7:0]  ent_q;
  snap_t       in_q;

  logic [63:0] nx_q, ny_q, na_q;
  logic        negx_q, negy_q, nega_q;
  logic [31:0] den_q;
  logic [63:0] qx, qy, qa;
  logic        div_done;
  logic [31:0] rx_q, ry_q, ra_q;

  logic [31:0] kk;

  assign addr = cmd_i.init ? init_q : {ent_q[EntW-1:0], cmd_i.slot};

  always_comb begin
    wdat = rd_q;
    if (cmd_i.init || cmd_i.wr_clr)
      wdat = '{stamp: '0, x: '0, y: '0, ang: '0, parent: NoParent};
    else if (cmd_i.wr_new) wdat = in_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.wr) mem_q[addr] <= wdat;
    if (cmd_i.rd) rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      init_done_q <= 1'b0;
    end else if (cmd_i.init) begin
      init_q <= init_q + 1'b1;
      if (init_q == AddrW'(Entities*Depth - 1)) init_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_if.action;
      ent_q <= in_if.entity;
      in_q  <= '{stamp: in_if.stamp, x: in_if.pos_x, y: in_if.pos_y,
                 ang: in_if.angle, parent: in_if.parent_id};
    end
    if (cmd_i.rd_cap) begin
      prev_q <= cur_q;
      cur_q  <= rd_q;
    end
  end

  assign kk = in_q.stamp - prev_q.stamp;

  function automatic logic [64:0] mag_mul(input logic [31:0] f, input logic [31:0] t,
                                          input logic [31:0] k);
    logic signed [32:0] dl;
    logic [32:0] m;
    logic [63:0] p;
    dl = $signed({t[31], t}) - $signed({f[31], f});
    m  = dl[32] ? 33'(-dl) : 33'(dl);
    p  = 64'(m) * 64'(k);
    return {dl[32], p};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      {negx_q, nx_q} <= mag_mul(prev_q.x, cur_q.x, kk);
      {negy_q, ny_q} <= mag_mul(prev_q.y, cur_q.y, kk);
      {nega_q, na_q} <= mag_mul(prev_q.ang, cur_q.ang, kk);
      den_q <= cur_q.stamp - prev_q.stamp;
    end
  end

  logic div_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_go_q <= 1'b0;
    else div_go_q <= cmd_i.div_start;
  end

  tsi_div u_div (
    .clk_i, .rst_ni, .start_i(div_go_q),
    .num_x_i(nx_q), .num_y_i(ny_q), .num_a_i(na_q), .den_i(den_q),
    .q_x_o(qx), .q_y_o(qy), .q_a_o(qa), .done_o(div_done)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] f, input logic [63:0] q,
                                          input logic neg);
    logic signed [35:0] v;
    if (q > 64'h4_0000_0000) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = neg ? $signed({{4{f[31]}}, f}) - $signed({1'b0, q[34:0]})
            : $signed({{4{f[31]}}, f}) + $signed({1'b0, q[34:0]});
    if (v > 36'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -36'sh0_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      rx_q <= sat_add(prev_q.x, qx, negx_q);
      ry_q <= sat_add(prev_q.y, qy, negy_q);
      ra_q <= sat_add(prev_q.ang, qa, nega_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (cmd_i.out_load) out_if.valid <= 1'b1;
    else if (out_if.ready) out_if.valid <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_if.status <= cmd_i.status;
      if (cmd_i.status == ST_VALID) begin
        out_if.out_x       <= cmd_i.interp ? rx_q : cur_q.x;
        out_if.out_y       <= cmd_i.interp ? ry_q : cur_q.y;
        out_if.out_angle   <= cmd_i.interp ? ra_q : cur_q.ang;
        out_if.out_parent  <= cur_q.parent;
        out_if.link_parent <= cur_q.parent != NoParent;
      end else begin
        out_if.out_x <= '0; out_if.out_y <= '0; out_if.out_angle <= '0;
        out_if.out_parent <= NoParent; out_if.link_parent <= 1'b0;
      end
    end
  end

  assign sts_o.init_done = init_done_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.inrange   = 32'(ent_q) < Entities;
  assign sts_o.newer     = rd_q.stamp < in_q.stamp;
  assign sts_o.zero_t    = in_q.stamp == '0;
  assign sts_o.later     = rd_q.stamp > in_q.stamp;
  assign sts_o.rd_zero   = rd_q.stamp == '0;
  assign sts_o.prev_ok   = prev_q.stamp != '0 && cur_q.stamp > prev_q.stamp &&
                           in_q.stamp >= prev_q.stamp;
  assign sts_o.action    = act_q;
endmodule

FILE: rtl/tsi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_ctrl: sequencer of the snapshot interpolator
// Clear pass, insert shift, clear, query scan and interpolation steps.
// ----------------------------------------------------------------------------
module tsi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_valid_i,
  input  tsi_pkg::sts_t sts_i,
  output tsi_pkg::cmd_t cmd_o
);
  import tsi_pkg::*;

  state_e state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [1:0] st_q, st_d;
  logic interp_q, interp_d;
  logic last;

  assign last = slot_q == SlotW'(Depth - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; slot_q <= '0; st_q <= ST_DONE; interp_q <= 1'b0;
    end else begin
      state_q <= state_d; slot_q <= slot_d; st_q <= st_d; interp_q <= interp_d;
    end
  end

  always_comb begin
    state_d = state_q; slot_d = slot_q; st_d = st_q; interp_d = interp_q;
    case (state_q)
      S_INIT: if (sts_i.init_done) state_d = S_IDLE;
      S_IDLE: if (in_valid_i && !out_valid_i) begin
        state_d = S_CHK; slot_d = '0; st_d = ST_DONE; interp_d = 1'b0;
      end
      S_CHK: begin
        if (!sts_i.inrange) begin
          st_d = (sts_i.action == ACT_QUERY) ? ST_SKIP : ST_DONE;
          state_d = S_OUT;
        end else if (sts_i.action == ACT_CLEAR) begin
          state_d = S_WR;
        end else if (sts_i.action == ACT_INSERT || sts_i.action == ACT_QUERY) begin
          slot_d = SlotW'(Depth - 1); state_d = S_RD;
        end else state_d = S_OUT;
      end
      S_RD: state_d = S_RDW;
      S_RDW: begin
        if (sts_i.action == ACT_INSERT) begin
          if (!sts_i.newer) begin
            st_d = ST_STALE; state_d = S_OUT;
          end else begin
            slot_d = '0; state_d = (Depth > 1) ? S_SCAN : S_WR;
          end
        end else if (sts_i.zero_t || sts_i.rd_zero) begin
          st_d = ST_SKIP; state_d = S_OUT;
        end else begin
          slot_d = '0; state_d = S_SCAN;
        end
      end
      S_SCAN: state_d = S_SCANW;
      S_SCANW: begin
        if (sts_i.action == ACT_INSERT) begin
          // read slot+1 done; write it into slot
          state_d = S_WR;
        end else if (sts_i.later || last) begin
          st_d = ST_VALID;
          if (slot_q == '0) state_d = S_OUT;
          else state_d = S_DIV;
        end else begin
          slot_d = slot_q + 1'b1; state_d = S_SCAN;
        end
      end
      S_WR: begin
        if (last) state_d = S_OUT;
        else begin
          slot_d = slot_q + 1'b1;
          if (sts_i.action == ACT_INSERT && slot_q != SlotW'(Depth - 2))
            state_d = S_SCAN;
        end
      end
      S_DIV: begin
        if (!sts_i.prev_ok) state_d = S_OUT;
        else begin
          interp_d = 1'b1; state_d = S_ADD;
        end
      end
      S_ADD: if (sts_i.div_done) state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.slot   = slot_q;
    cmd_o.status = st_q;
    cmd_o.interp = interp_q;
    in_ready_o = (state_q == S_IDLE) && !out_valid_i;
    case (state_q)
      S_INIT: cmd_o.init = 1'b1;
      S_IDLE: cmd_o.load = in_valid_i && !out_valid_i;
      S_RD: cmd_o.rd = 1'b1;
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.action == ACT_INSERT) cmd_o.slot = slot_q + 1'b1;
      end
      S_SCANW: if (sts_i.action == ACT_QUERY) cmd_o.rd_cap = 1'b1;
      S_WR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wr_clr = sts_i.action == ACT_CLEAR;
        cmd_o.wr_new = sts_i.action == ACT_INSERT && last;
      end
      S_DIV: cmd_o.div_start = sts_i.prev_ok;
      S_ADD: cmd_o.add = sts_i.div_done;
      S_OUT: cmd_o.out_load = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: rtl/timestamped_snapshot_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_snapshot_interpolator: per-entity snapshot buffer with lerp
//
//  channel | dir | payload
//  in_if   | in  | action, entity, stamp, pos_x, pos_y, angle, parent_id
//  out_if  | out | status, out_x, out_y, out_angle, out_parent, link_parent
//
// One transaction at a time. A query that interpolates uses the shared divider.
// After reset a clearing pass over all Entities*Depth (1024) slots runs first.
// A new transaction is taken only when the result register is empty.
// ----------------------------------------------------------------------------
module timestamped_snapshot_interpolator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsi_in_if.sink    in_if,
  tsi_out_if.source out_if
);
  import tsi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_i(out_if.valid), .sts_i(sts), .cmd_o(cmd)
  );

  tsi_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_if(in_if), .out_if(out_if)
  );
endmodule

FILE: bench/timestamped_snapshot_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_snapshot_interpolator_test: self-checking bench of the interpolator
// Keeps a private copy of every entity's snapshot buffer and predicts the result
// of each transaction. Directed special cases come first, then random
// insert/clear/query traffic with random idling on both channels outside a
// quiet phase. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module timestamped_snapshot_interpolator_test;
  import tsi_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] ang;
    logic [15:0] parent;
    logic        link;
  } prediction_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  tsi_in_if  in_if ();
  tsi_out_if out_if ();

  timestamped_snapshot_interpolator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  logic [31:0] buf_stamp [Entities*Depth];
  logic [31:0] buf_x     [Entities*Depth];
  logic [31:0] buf_y     [Entities*Depth];
  logic [31:0] buf_ang   [Entities*Depth];
  logic [15:0] buf_par   [Entities*Depth];

  prediction_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int queries_valid = 0;
  longint cycles = 0;
  bit calm = 1'b0;

  function automatic logic [31:0] lerp_sat(logic [31:0] from, logic [31:0] to,
                                           logic [31:0] k, logic [31:0] d);
    longint f, delta, v;
    bit neg;
    logic [63:0] mag, q;
    f = longint'($signed(from));
    delta = longint'($signed(to)) - f;
    neg = delta < 0;
    mag = neg ? -delta : delta;
    q = (mag * {32'd0, k}) / {32'd0, d};
    if (q > 64'h4_0000_0000) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = neg ? f - longint'(q) : f + longint'(q);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void clear_buffer(int base);
    for (int i = 0; i < Depth; i++) begin
      buf_stamp[base+i] = '0; buf_x[base+i] = '0; buf_y[base+i] = '0;
      buf_ang[base+i] = '0; buf_par[base+i] = NoParent;
    end
  endfunction

  function automatic prediction_t predict_snapshot(action_e act, logic [7:0] ent,
      logic [31:0] t, logic [31:0] px, logic [31:0] py, logic [31:0] pa,
      logic [15:0] pp);
    prediction_t p;
    int base, last, best, to, fr;
    logic [31:0] fs, ts;
    p = '{status: ST_DONE, x: '0, y: '0, ang: '0, parent: NoParent, link: 1'b0};
    base = int'(ent) * Depth;
    last = base + Depth - 1;
    case (act)
      ACT_INSERT: begin
        if (buf_stamp[last] < t) begin
          for (int i = 0; i < Depth - 1; i++) begin
            buf_stamp[base+i] = buf_stamp[base+i+1]; buf_x[base+i] = buf_x[base+i+1];
            buf_y[base+i] = buf_y[base+i+1]; buf_ang[base+i] = buf_ang[base+i+1];
            buf_par[base+i] = buf_par[base+i+1];
          end
          buf_stamp[last] = t; buf_x[last] = px; buf_y[last] = py;
          buf_ang[last] = pa; buf_par[last] = pp;
        end else begin
          p.status = ST_STALE;
        end
      end
      ACT_CLEAR: clear_buffer(base);
      ACT_QUERY: begin
        if (t == 0 || buf_stamp[last] == 0) begin
          p.status = ST_SKIP;
        end else begin
          best = 0;
          for (int i = 0; i < Depth; i++) begin
            best = i;
            if (buf_stamp[base+i] > t) break;
          end
          to = base + best;
          p.x = buf_x[to]; p.y = buf_y[to]; p.ang = buf_ang[to];
          if (best != 0) begin
            fr = to - 1;
            fs = buf_stamp[fr];
            ts = buf_stamp[to];
            if (fs != 0 && ts > fs && t >= fs) begin
              p.x = lerp_sat(buf_x[fr], buf_x[to], t - fs, ts - fs);
              p.y = lerp_sat(buf_y[fr], buf_y[to], t - fs, ts - fs);
              p.ang = lerp_sat(buf_ang[fr], buf_ang[to], t - fs, ts - fs);
            end
          end
          p.status = ST_VALID;
          p.parent = buf_par[to];
          p.link = buf_par[to] != NoParent;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_transaction(action_e act, logic [7:0] ent, logic [31:0] t,
      logic [31:0] px, logic [31:0] py, logic [31:0] pa, logic [15:0] pp);
    while (!calm && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act; in_if.entity <= ent; in_if.stamp <= t;
    in_if.pos_x <= px; in_if.pos_y <= py; in_if.angle <= pa; in_if.parent_id <= pp;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_snapshot(act, ent, t, px, py, pa, pp));
    @(negedge clk_i);
  endtask

  task automatic send_random(action_e act, logic [7:0] ent, logic [31:0] t);
    send_transaction(act, ent, t, $urandom, $urandom, $urandom,
                     $urandom_range(3) == 0 ? NoParent : 16'($urandom));
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    prediction_t e;
    cycles++;
    if (cycles > 1000000) begin
      $display("timestamped_snapshot_interpolator_test NOT OK");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result, status %0d", out_if.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.status == ST_VALID) queries_valid++;
        if (out_if.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_if.status); errors++;
        end
        if (out_if.out_x !== e.x) begin
          $error("out_x: expected %h, got %h", e.x, out_if.out_x); errors++;
        end
        if (out_if.out_y !== e.y) begin
          $error("out_y: expected %h, got %h", e.y, out_if.out_y); errors++;
        end
        if (out_if.out_angle !== e.ang) begin
          $error("out_angle: expected %h, got %h", e.ang, out_if.out_angle); errors++;
        end
        if (out_if.out_parent !== e.parent) begin
          $error("out_parent: expected %h, got %h", e.parent, out_if.out_parent); errors++;
        end
        if (out_if.link_parent !== e.link) begin
          $error("link_parent: expected %b, got %b", e.link, out_if.link_parent); errors++;
        end
      end
    end
  end

  task automatic test_special_cases();
    send_random(ACT_QUERY, 8'd0, 32'd100);
    send_random(ACT_QUERY, 8'd255, 32'd0);
    send_transaction(ACT_INSERT, 8'd0, 32'd10, 32'h0001_0000, 32'hFFFF_0000,
                     32'h7FFF_FFFF, 16'd7);
    send_random(ACT_QUERY, 8'd0, 32'd0);
    send_random(ACT_QUERY, 8'd0, 32'd5);
    send_random(ACT_QUERY, 8'd0, 32'd50);
    send_random(ACT_INSERT, 8'd0, 32'd10);
    send_random(ACT_INSERT, 8'd0, 32'd3);
    send_transaction(ACT_INSERT, 8'd0, 32'd20, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, NoParent);
    send_random(ACT_QUERY, 8'd0, 32'd15);
    send_random(ACT_QUERY, 8'd0, 32'hFFFF_FFFF);
    send_random(ACT_QUERY, 8'd0, 32'd10);
    send_transaction(ACT_INSERT, 8'd255, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'd0, 16'hFFFE);
    send_transaction(ACT_INSERT, 8'd255, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 16'd0);
    send_random(ACT_QUERY, 8'd255, 32'hFFFF_FFFF);
    send_random(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_random(ACT_NONE, 8'd0, 32'd1);
    send_random(ACT_CLEAR, 8'd0, 32'd0);
    send_random(ACT_QUERY, 8'd0, 32'd15);
    send_random(ACT_CLEAR, 8'd255, 32'd0);
    send_random(ACT_QUERY, 8'd255, 32'd7);
  endtask

  task automatic test_random_traffic(int n, bit quiet);
    int ent, r;
    logic [31:0] stamp_now [16];
    for (int i = 0; i < 16; i++) stamp_now[i] = $urandom_range(1, 1000);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      ent = $urandom_range(15);
      r = $urandom_range(99);
      if (r < 45) begin
        stamp_now[ent] += $urandom_range(1, 2000);
        send_random(ACT_INSERT, 8'(ent), stamp_now[ent]);
      end else if (r < 85) begin
        send_random(ACT_QUERY, 8'(ent), stamp_now[ent] - 3000 + $urandom_range(6000));
      end else if (r < 92) begin
        send_random(ACT_INSERT, 8'($urandom), $urandom);
      end else if (r < 96) begin
        send_random(ACT_QUERY, 8'($urandom), $urandom);
      end else if (r < 98) begin
        send_random(ACT_CLEAR, 8'(ent), $urandom);
      end else begin
        send_random(ACT_NONE, 8'($urandom), $urandom);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int guard;
    in_if.valid = 1'b0; in_if.action = ACT_NONE; in_if.entity = '0; in_if.stamp = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.angle = '0; in_if.parent_id = '0;
    out_if.ready = 1'b0;
    for (int e = 0; e < Entities; e++) clear_buffer(e * Depth);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_special_cases();
    test_random_traffic(1100, 1'b0);
    test_random_traffic(250, 1'b1);
    test_random_traffic(200, 1'b0);
    in_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    $display("Checked %0d results, %0d of them valid predictions.", results_seen,
             queries_valid);
    if (errors == 0 && pending_results.size() == 0)
      $display("timestamped_snapshot_interpolator_test OK");
    else
      $display("timestamped_snapshot_interpolator_test NOT OK");
    $finish;
  end

endmodule

FILE: timestamped_snapshot_interpolator.f
rtl/tsi_pkg.sv
rtl/tsi_if.sv
rtl/tsi_div.sv
rtl/tsi_datapath.sv
rtl/tsi_ctrl.sv
rtl/timestamped_snapshot_interpolator.sv
bench/timestamped_snapshot_interpolator_test.sv
